### hw/rtl/rqrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rqrm_pkg;

  localparam int DEPTH       = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 8;
  localparam int IDX_BITS    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS    = $clog2(DEPTH + 1);
  localparam int SUM_BITS    = SAMPLE_BITS + IDX_BITS;
  localparam int MEAN_BITS   = SAMPLE_BITS + FRAC_BITS;
  localparam int DVD_BITS    = SUM_BITS + FRAC_BITS;
  localparam int STEP_BITS   = $clog2(DVD_BITS + 1);

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_STAT = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  localparam logic [CNT_BITS-1:0] CAP_RESET = CNT_BITS'(DEPTH);

  typedef struct packed {
    logic [1:0]                    opcode;
    logic signed [SAMPLE_BITS-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] front_value;
    logic [CNT_BITS-1:0]           count;
    logic                          is_full;
    logic                          is_empty;
    logic signed [MEAN_BITS-1:0]   mean_q8;
    logic [1:0]                    status;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_STAT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                     kind;
    logic signed [SAMPLE_BITS-1:0] sample;
  } cmd_t;

endpackage
`default_nettype wire

### hw/rtl/ring_queue_running_mean.sv
`timescale 1ns / 1ps
`default_nettype none
// Circular queue of signed samples with a running mean of its contents.
// A command beat is taken on in_item when start is high and busy is low.
// The opcode enqueues the sample, dequeues the front entry, or only asks
// for status. Each command yields exactly one result beat on out_item,
// marked by out_strobe for a single cycle; the receiver cannot hold it off.
// A result reports the front entry, the count, the full and empty flags,
// the mean in signed fixed point with eight fraction bits, and a status.
// Commands pass through a two-entry queue to the execution unit, and busy
// is high while that queue is full. The execution unit takes the next
// command from that queue only after the result of the last one is out;
// the serial divider that forms the mean yields one quotient bit per
// cycle over the 28-bit scaled sum. Writing cfg_wdata with cfg_we sets the
// capacity and empties the queue; write it only while no command is open.
// Reset empties the queue and sets the capacity to the full depth of 16.
module ring_queue_running_mean
  import rqrm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire in_item_t            in_item,
  output logic                     out_strobe,
  output out_item_t                out_item,
  input  wire logic                cfg_we,
  input  wire logic [CNT_BITS-1:0] cfg_wdata
);

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t q_in_cmd;
  cmd_t q_out_cmd;

  rqrm_front u_front (
    .start   (start),
    .in_item (in_item),
    .q_full  (q_full),
    .busy    (busy),
    .q_push  (q_push),
    .q_cmd   (q_in_cmd)
  );

  rqrm_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .pop      (q_pop),
    .pop_cmd  (q_out_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  rqrm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_empty    (q_empty),
    .q_cmd      (q_out_cmd),
    .q_pop      (q_pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result beats on consecutive cycles");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_item.is_empty == (out_item.count == '0)))
    else $error("empty flag disagrees with count");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_item.status == ST_OVERFLOW)) |-> out_item.is_full)
    else $error("overflow reported while not full");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_item.count <= CNT_BITS'(DEPTH)))
    else $error("count beyond depth");

endmodule
`default_nettype wire

### hw/rtl/rqrm_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rqrm_front
  import rqrm_pkg::*;
(
  input  wire logic     start,
  input  wire in_item_t in_item,
  input  wire logic     q_full,
  output logic          busy,
  output logic          q_push,
  output cmd_t          q_cmd
);

  // Unused opcodes behave as a status request.
  always_comb begin
    case (in_item.opcode)
      OP_PUSH: q_cmd.kind = CMD_PUSH;
      OP_POP:  q_cmd.kind = CMD_POP;
      OP_STAT: q_cmd.kind = CMD_STAT;
      default: q_cmd.kind = CMD_STAT;
    endcase
    q_cmd.sample = in_item.sample;
  end

  assign busy   = q_full;
  assign q_push = start & ~q_full;

endmodule
`default_nettype wire

### hw/rtl/rqrm_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module rqrm_fifo
  import rqrm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      pop_cmd,
  output logic      full,
  output logic      empty
);

  cmd_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] level_r;

  assign full    = (level_r == 2'd2);
  assign empty   = (level_r == 2'd0);
  assign pop_cmd = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      level_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   level_r <= level_r + 2'd1;
        2'b01:   level_r <= level_r - 2'd1;
        default: level_r <= level_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/rqrm_div.sv
`timescale 1ns / 1ps
`default_nettype none
module rqrm_div
  import rqrm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [DVD_BITS-1:0] dividend,
  input  wire logic [CNT_BITS-1:0] divisor,
  output logic                     done,
  output logic [DVD_BITS-1:0]      quotient
);

  logic                 busy_r;
  logic                 done_r;
  logic [STEP_BITS-1:0] step_r;
  logic [DVD_BITS-1:0]  acc_r;
  logic [CNT_BITS-1:0]  rem_r;
  logic [CNT_BITS-1:0]  dsr_r;
  logic [CNT_BITS:0]    shifted;
  logic                 ge;
  logic [CNT_BITS:0]    diff;

  // Restoring division, one quotient bit per cycle; the quotient shifts
  // into the accumulator as the dividend shifts out.
  always_comb begin
    shifted = {rem_r, acc_r[DVD_BITS-1]};
    ge      = (shifted >= {1'b0, dsr_r});
    diff    = shifted - {1'b0, dsr_r};
  end

  assign done     = done_r;
  assign quotient = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_BITS'(1);
        if (step_r == STEP_BITS'(DVD_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      acc_r <= {acc_r[DVD_BITS-2:0], ge};
      rem_r <= ge ? diff[CNT_BITS-1:0] : shifted[CNT_BITS-1:0];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/rqrm_back.sv
`timescale 1ns / 1ps
`default_nettype none
module rqrm_back
  import rqrm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CNT_BITS-1:0] cfg_wdata,
  input  wire logic                q_empty,
  input  wire cmd_t                q_cmd,
  output logic                     q_pop,
  output logic                     out_strobe,
  output out_item_t                out_item
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LAUNCH,
    S_DIV
  } state_t;

  state_t                        state_r;
  cmd_t                          cmd_r;
  logic [CNT_BITS-1:0]           cap_r;
  logic [IDX_BITS-1:0]           head_r;
  logic [IDX_BITS-1:0]           head_nxt;
  logic [CNT_BITS-1:0]           fill_r;
  logic [CNT_BITS-1:0]           fill_nxt;
  logic signed [SUM_BITS-1:0]    sum_r;
  logic signed [SUM_BITS-1:0]    sum_nxt;
  logic [1:0]                    status_r;
  logic [1:0]                    status_nxt;
  logic                          out_strobe_r;
  out_item_t                     out_item_r;

  logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_data_r;
  logic                          wr_en;
  logic [IDX_BITS-1:0]           wr_idx;

  logic [CNT_BITS-1:0]           cap_eff;
  logic [CNT_BITS:0]             pos_wide;
  logic [CNT_BITS:0]             pos_wrap;
  logic [CNT_BITS:0]             head_inc;
  logic                          at_full;
  logic                          sum_neg;
  logic [SUM_BITS-1:0]           sum_mag;
  logic                          div_start;
  logic                          div_done;
  logic [DVD_BITS-1:0]           div_quo;
  logic [MEAN_BITS-1:0]          mean_mag;
  logic signed [MEAN_BITS-1:0]   mean_val;

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CNT_BITS'(1);
    end else if (cap_r > CNT_BITS'(DEPTH)) begin
      cap_eff = CNT_BITS'(DEPTH);
    end else begin
      cap_eff = cap_r;
    end
    at_full  = (fill_r >= cap_eff);
    pos_wide = {1'b0, CNT_BITS'(head_r)} + {1'b0, fill_r};
    pos_wrap = pos_wide - {1'b0, cap_eff};
    wr_idx   = (pos_wide >= {1'b0, cap_eff}) ? pos_wrap[IDX_BITS-1:0]
                                             : pos_wide[IDX_BITS-1:0];
    head_inc = {1'b0, CNT_BITS'(head_r)} + (CNT_BITS + 1)'(1);
  end

  always_comb begin
    head_nxt   = head_r;
    fill_nxt   = fill_r;
    sum_nxt    = sum_r;
    status_nxt = ST_OK;
    wr_en      = 1'b0;
    case (cmd_r.kind)
      CMD_PUSH: begin
        if (at_full) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          wr_en    = 1'b1;
          fill_nxt = fill_r + CNT_BITS'(1);
          sum_nxt  = sum_r + {{(SUM_BITS - SAMPLE_BITS){cmd_r.sample[SAMPLE_BITS-1]}},
                              cmd_r.sample};
        end
      end
      CMD_POP: begin
        if (fill_r == '0) begin
          status_nxt = ST_UNDERFLOW;
        end else begin
          head_nxt = (head_inc == {1'b0, cap_eff}) ? '0 : head_inc[IDX_BITS-1:0];
          fill_nxt = fill_r - CNT_BITS'(1);
          sum_nxt  = sum_r - {{(SUM_BITS - SAMPLE_BITS){rd_data_r[SAMPLE_BITS-1]}},
                              rd_data_r};
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // The dividend is the magnitude of the sum scaled by the fraction bits;
  // the sign is put back on the quotient.
  always_comb begin
    sum_neg   = sum_r[SUM_BITS-1];
    sum_mag   = sum_neg ? SUM_BITS'(-sum_r) : SUM_BITS'(sum_r);
    div_start = (state_r == S_LAUNCH);
    q_pop     = (state_r == S_IDLE) && !q_empty && !cfg_we;
    mean_mag  = div_quo[MEAN_BITS-1:0];
    mean_val  = sum_neg ? -signed'(mean_mag) : signed'(mean_mag);
  end

  rqrm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({sum_mag, {FRAC_BITS{1'b0}}}),
    .divisor  (fill_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (wr_en && (state_r == S_EXEC)) begin
      mem[wr_idx] <= cmd_r.sample;
    end
    rd_data_r <= mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cap_r        <= CAP_RESET;
      head_r       <= '0;
      fill_r       <= '0;
      sum_r        <= '0;
      status_r     <= ST_OK;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (cfg_we) begin
        cap_r  <= cfg_wdata;
        head_r <= '0;
        fill_r <= '0;
        sum_r  <= '0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            cmd_r   <= q_cmd;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          head_r   <= head_nxt;
          fill_r   <= fill_nxt;
          sum_r    <= sum_nxt;
          status_r <= status_nxt;
          state_r  <= S_LAUNCH;
        end
        S_LAUNCH: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            out_strobe_r            <= 1'b1;
            out_item_r.count        <= fill_r;
            out_item_r.is_full      <= at_full;
            out_item_r.is_empty     <= (fill_r == '0);
            out_item_r.status       <= status_r;
            out_item_r.front_value  <= (fill_r == '0) ? '1 : rd_data_r;
            out_item_r.mean_q8      <= (fill_r == '0) ? '0 : mean_val;
            state_r                 <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule
`default_nettype wire

### test/tb_ring_queue_running_mean.sv
`timescale 1ns / 1ps
module tb_ring_queue_running_mean;
  import rqrm_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int LIMIT_CYCLES = 1000000;
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum int {FILL_MAX, FILL_MIN, FILL_MIXED} fill_style_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  in_item_t            in_item = '0;
  logic                out_strobe;
  out_item_t           out_item;
  logic                cfg_we = 1'b0;
  logic [CNT_BITS-1:0] cfg_wdata = '0;

  ring_queue_running_mean u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  logic signed [SAMPLE_BITS-1:0] ent_mem [DEPTH];
  int unsigned                   q_head = 0;
  int unsigned                   q_fill = 0;
  longint                        q_sum = 0;
  logic [CNT_BITS-1:0]           cap_reg = CAP_RESET;

  out_item_t predicted_q [$];
  int        mismatch_cnt = 0;
  int        sender_idle_pct = 0;
  int        cycle_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int unsigned eff_cap();
    if (cap_reg == 0) return 1;
    if (cap_reg > DEPTH) return DEPTH;
    return cap_reg;
  endfunction

  task automatic queue_model_step(input in_item_t it, output out_item_t res);
    int unsigned cap;
    int unsigned pos;
    cap = eff_cap();
    res = '0;
    res.status = ST_OK;
    case (it.opcode)
      OP_PUSH: begin
        if (q_fill >= cap) begin
          res.status = ST_OVERFLOW;
        end else begin
          pos = (q_head + q_fill) % cap;
          ent_mem[pos] = it.sample;
          q_fill++;
          q_sum += it.sample;
        end
      end
      OP_POP: begin
        if (q_fill == 0) begin
          res.status = ST_UNDERFLOW;
        end else begin
          q_sum -= ent_mem[q_head % cap];
          q_head = (q_head + 1) % cap;
          q_fill--;
        end
      end
      default: ;
    endcase
    if (q_fill != 0) begin
      res.front_value = ent_mem[q_head % cap];
      res.mean_q8 = MEAN_BITS'((q_sum * (longint'(1) << FRAC_BITS)) / longint'(q_fill));
    end else begin
      res.front_value = '1;
      res.mean_q8 = '0;
    end
    res.count = CNT_BITS'(q_fill);
    res.is_full = (q_fill >= cap);
    res.is_empty = (q_fill == 0);
  endtask

  task automatic cmp_field(input string fname, input logic signed [31:0] want,
                           input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (predicted_q.size() == 0) begin
        $display("%0t: result beat with none expected, expected none, actual %h",
                 $time, out_item);
        mismatch_cnt++;
      end else begin
        want = predicted_q.pop_front();
        cmp_field("front_value", want.front_value, out_item.front_value);
        cmp_field("count", want.count, out_item.count);
        cmp_field("is_full", want.is_full, out_item.is_full);
        cmp_field("is_empty", want.is_empty, out_item.is_empty);
        cmp_field("mean_q8", want.mean_q8, out_item.mean_q8);
        cmp_field("status", want.status, out_item.status);
      end
    end
  end

  // Must be called in the time step of a rising edge. It leaves start high so
  // that back-to-back beats need no second assignment in one step.
  task automatic send_cmd(input logic [1:0] op, input logic signed [SAMPLE_BITS-1:0] smp);
    in_item_t    item;
    out_item_t   res;
    int unsigned gap;
    item.opcode = op;
    item.sample = smp;
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      gap = $urandom_range(1, 40);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy);
    queue_model_step(item, res);
    predicted_q.push_back(res);
  endtask

  task automatic write_capacity(input logic [CNT_BITS-1:0] cap_val);
    start <= 1'b0;
    while (predicted_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= cap_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_reg = cap_val;
    q_head = 0;
    q_fill = 0;
    q_sum = 0;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input fill_style_t style);
    case (style)
      FILL_MAX: return SMP_MAX;
      FILL_MIN: return SMP_MIN;
      default: begin
        case ($urandom_range(7))
          0: return SMP_MAX;
          1: return SMP_MIN;
          2: return SAMPLE_BITS'($signed($urandom_range(8)) - 4);
          default: return SAMPLE_BITS'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic test_empty_queue();
    send_cmd(OP_STAT, '0);
    send_cmd(OP_POP, SMP_MAX);
    send_cmd(OP_SPARE, '1);
  endtask

  task automatic test_push_pop_extremes();
    send_cmd(OP_PUSH, SMP_MAX);
    send_cmd(OP_PUSH, SMP_MIN);
    send_cmd(OP_PUSH, SAMPLE_BITS'(-1));
    send_cmd(OP_STAT, '0);
    repeat (3) send_cmd(OP_POP, '0);
    send_cmd(OP_POP, '0);
  endtask

  task automatic test_capacity_limits();
    write_capacity(CNT_BITS'(1));
    send_cmd(OP_PUSH, SAMPLE_BITS'(7));
    send_cmd(OP_PUSH, SAMPLE_BITS'(9));
    send_cmd(OP_POP, '0);
    send_cmd(OP_POP, '0);
    write_capacity(CNT_BITS'(0));
    send_cmd(OP_PUSH, SMP_MIN);
    send_cmd(OP_PUSH, SAMPLE_BITS'(1));
    write_capacity(CNT_BITS'(2));
    send_cmd(OP_PUSH, SMP_MAX);
    send_cmd(OP_PUSH, SMP_MAX);
    send_cmd(OP_PUSH, SMP_MIN);
    send_cmd(OP_POP, '0);
    send_cmd(OP_PUSH, SMP_MIN);
  endtask

  task automatic test_reconfig_while_filled();
    write_capacity(CNT_BITS'(31));
    send_cmd(OP_PUSH, SAMPLE_BITS'(100));
    send_cmd(OP_PUSH, SAMPLE_BITS'(-200));
    write_capacity(CNT_BITS'(16));
    send_cmd(OP_STAT, '0);
    send_cmd(OP_POP, '0);
  endtask

  task automatic run_traffic(input int n_items);
    int          done_cnt;
    int          burst;
    int          r;
    fill_style_t style;
    done_cnt = 0;
    while (done_cnt < n_items) begin
      r = $urandom_range(99);
      style = fill_style_t'($urandom_range(2));
      if (r < 30) begin
        burst = int'(eff_cap()) - int'(q_fill) + $urandom_range(2);
        for (int i = 0; i < burst; i++) send_cmd(OP_PUSH, pick_sample(style));
      end else if (r < 50) begin
        burst = int'(q_fill) + $urandom_range(2);
        for (int i = 0; i < burst; i++) send_cmd(OP_POP, SAMPLE_BITS'($urandom));
      end else begin
        burst = $urandom_range(1, 20);
        for (int i = 0; i < burst; i++) begin
          r = $urandom_range(99);
          if (r < 45) send_cmd(OP_PUSH, pick_sample(FILL_MIXED));
          else if (r < 80) send_cmd(OP_POP, SAMPLE_BITS'($urandom));
          else if (r < 95) send_cmd(OP_STAT, SAMPLE_BITS'($urandom));
          else send_cmd(OP_SPARE, SAMPLE_BITS'($urandom));
        end
      end
      done_cnt += burst;
    end
  endtask

  task automatic test_random_traffic();
    int caps [12];
    int pcts [3];
    caps = '{16, 1, 0, 31, 2, 3, 15, 17, 8, 16, 5, 16};
    pcts = '{0, 78, 20};
    for (int p = 0; p < 12; p++) begin
      write_capacity(CNT_BITS'(caps[p]));
      sender_idle_pct = pcts[p % 3];
      run_traffic(140);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_queue();
    test_push_pop_extremes();
    test_capacity_limits();
    test_reconfig_while_filled();
    test_random_traffic();
    start <= 1'b0;
    while (predicted_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/rqrm_pkg.sv
hw/rtl/rqrm_front.sv
hw/rtl/rqrm_fifo.sv
hw/rtl/rqrm_div.sv
hw/rtl/rqrm_back.sv
hw/rtl/ring_queue_running_mean.sv
test/tb_ring_queue_running_mean.sv
